FILE: rtl/core/dual_incremental_pi_motor_drive_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual incremental PI motor drive
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DUAL_INCREMENTAL_PI_MOTOR_DRIVE_TOP_MACROS_SVH
`define DUAL_INCREMENTAL_PI_MOTOR_DRIVE_TOP_MACROS_SVH

// same-cycle implication
`define DIPMD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dipmd assertion failed: same-cycle check");

// next-cycle implication
`define DIPMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dipmd assertion failed: next-cycle check");

`endif

FILE: rtl/core/dipmd_pkg.sv
// ----------------------------------------------------------------------------
// dipmd_pkg
// Types and constants of the dual incremental PI motor drive.
// ----------------------------------------------------------------------------
package dipmd_pkg;

   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 12;
   localparam int DRIVE_W    = 13;
   localparam int DUTY_W     = 12;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT = 2'd2;

   localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET   = 16'd256;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RESET  = 16'd128;
   localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RESET = 12'd3600;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop;
      logic [GAIN_W-1:0]  integ;
      logic [LIMIT_W-1:0] limit;
   } gains_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      forward;
      logic [DUTY_W-1:0]         duty;
   } drive_result_type;

endpackage

FILE: rtl/core/dipmd_if.sv
// ----------------------------------------------------------------------------
// dipmd_req_if / dipmd_rsp_if
// Valid/ready channels for speed samples in and drive commands out.
// ----------------------------------------------------------------------------
interface dipmd_req_if #(
   parameter int SPEED_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SPEED_WIDTH-1:0] target_a;
   logic signed [SPEED_WIDTH-1:0] measured_a;
   logic signed [SPEED_WIDTH-1:0] target_b;
   logic signed [SPEED_WIDTH-1:0] measured_b;

   modport source (output valid, target_a, measured_a, target_b, measured_b, input ready);
   modport sink   (input valid, target_a, measured_a, target_b, measured_b, output ready);
endinterface

interface dipmd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [12:0] drive_a;
   logic               forward_a;
   logic [11:0]        duty_a;
   logic signed [12:0] drive_b;
   logic               forward_b;
   logic [11:0]        duty_b;

   modport source (output valid, drive_a, forward_a, duty_a, drive_b, forward_b, duty_b,
                   input ready);
   modport sink   (input valid, drive_a, forward_a, duty_a, drive_b, forward_b, duty_b,
                   output ready);
endinterface

FILE: rtl/core/dipmd_axis.sv
// ----------------------------------------------------------------------------
// dipmd_axis
// Incremental PI law of one motor with its accumulated drive and last error.
// ----------------------------------------------------------------------------
module dipmd_axis
   import dipmd_pkg::*;
#(
   parameter int SPEED_WIDTH    = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic signed [SPEED_WIDTH-1:0] target,
   input  logic signed [SPEED_WIDTH-1:0] measured,
   input  gains_type                     gains,
   output drive_result_type              result
);

   localparam int ERR_W  = SPEED_WIDTH + 1;
   localparam int DIFF_W = SPEED_WIDTH + 2;
   localparam int PROD_W = SPEED_WIDTH + 19;
   localparam int SUM_W  = SPEED_WIDTH + 21;

   logic signed [DRIVE_W-1:0] accum_ff;
   logic signed [ERR_W-1:0]   prev_err_ff;

   logic signed [ERR_W-1:0]   err;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [GAIN_W:0]    pg;
   logic signed [GAIN_W:0]    ig;
   logic signed [PROD_W-1:0]  p_prod;
   logic signed [PROD_W-1:0]  i_prod;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   quo;
   logic signed [SUM_W-1:0]   trunc;
   logic signed [SUM_W-1:0]   lim_pos;
   logic signed [SUM_W-1:0]   clamped;
   logic signed [DRIVE_W-1:0] drive_in;

   always_comb begin
      err     = ERR_W'(target) - ERR_W'(measured);
      diff    = DIFF_W'(err) - DIFF_W'(prev_err_ff);
      pg      = $signed({1'b0, gains.prop});
      ig      = $signed({1'b0, gains.integ});
      p_prod  = PROD_W'(pg) * PROD_W'(err);
      i_prod  = PROD_W'(ig) * PROD_W'(diff);
      sum     = (SUM_W'(accum_ff) <<< GAIN_FRAC_BITS) + SUM_W'(p_prod) + SUM_W'(i_prod);
      quo     = sum >>> GAIN_FRAC_BITS;
      trunc   = quo + $signed(SUM_W'(sum[SUM_W-1] && (|sum[GAIN_FRAC_BITS-1:0])));
      lim_pos = $signed(SUM_W'(gains.limit));
      if (trunc > lim_pos) begin
         clamped = lim_pos;
      end else if (trunc < -lim_pos) begin
         clamped = -lim_pos;
      end else begin
         clamped = trunc;
      end
      drive_in       = DRIVE_W'(clamped);
      result.drive   = drive_in;
      result.forward = !drive_in[DRIVE_W-1] && (|drive_in);
      result.duty    = drive_in[DRIVE_W-1] ? DUTY_W'(-drive_in) : DUTY_W'(drive_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff    <= '0;
         prev_err_ff <= '0;
      end else if (step) begin
         accum_ff    <= drive_in;
         prev_err_ff <= err;
      end
   end

endmodule

FILE: rtl/core/dual_incremental_pi_motor_drive_top.sv
// ----------------------------------------------------------------------------
// dual_incremental_pi_motor_drive_top
// Two-motor incremental PI speed loop with symmetric drive clamp.
// ----------------------------------------------------------------------------
//   channel   dir  contents
//   req_chan  in   target and measured speed of motors A and B
//   rsp_chan  out  signed drive, direction and duty of motors A and B
//   csr_*     in   prop_gain (0), integ_gain (1), drive_limit (2)
//
// One transaction per cycle unless stalled; registered at input and output.
// The PI update is one pass of two multipliers, an adder and a clamp per motor.
// Synchronous reset clears both motors' drive and error history and restores
// the reset gains and limit.
// A stalled result holds in the output register; the input register keeps
// accepting until both stages are full.
// ----------------------------------------------------------------------------
module dual_incremental_pi_motor_drive_top
   import dipmd_pkg::*;
#(
   parameter int SPEED_WIDTH    = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   dipmd_req_if.sink             req_chan,
   dipmd_rsp_if.source           rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic signed [SPEED_WIDTH-1:0] target_a_ff;
   logic signed [SPEED_WIDTH-1:0] measured_a_ff;
   logic signed [SPEED_WIDTH-1:0] target_b_ff;
   logic signed [SPEED_WIDTH-1:0] measured_b_ff;

   logic                          out_valid_ff;
   logic                          out_valid_in;
   drive_result_type              res_a_ff;
   drive_result_type              res_b_ff;
   drive_result_type              res_a;
   drive_result_type              res_b;

   gains_type                     gains_ff;
   logic                          req_accept;
   logic                          advance;

   always_comb begin
      advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
      req_chan.ready = !in_valid_ff || advance;
      req_accept     = req_chan.valid && req_chan.ready;
      in_valid_in    = req_accept || (in_valid_ff && !advance);
      out_valid_in   = advance || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         target_a_ff   <= req_chan.target_a;
         measured_a_ff <= req_chan.measured_a;
         target_b_ff   <= req_chan.target_b;
         measured_b_ff <= req_chan.measured_b;
      end
      if (advance) begin
         res_a_ff <= res_a;
         res_b_ff <= res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop  <= PROP_GAIN_RESET;
         gains_ff.integ <= INTEG_GAIN_RESET;
         gains_ff.limit <= DRIVE_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_PROP_GAIN:   gains_ff.prop  <= csr_wdata;
            CSR_INTEG_GAIN:  gains_ff.integ <= csr_wdata;
            CSR_DRIVE_LIMIT: gains_ff.limit <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   dipmd_axis #(
      .SPEED_WIDTH    (SPEED_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_axis_a (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .target   (target_a_ff),
      .measured (measured_a_ff),
      .gains    (gains_ff),
      .result   (res_a)
   );

   dipmd_axis #(
      .SPEED_WIDTH    (SPEED_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_axis_b (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .target   (target_b_ff),
      .measured (measured_b_ff),
      .gains    (gains_ff),
      .result   (res_b)
   );

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.drive_a   = res_a_ff.drive;
   assign rsp_chan.forward_a = res_a_ff.forward;
   assign rsp_chan.duty_a    = res_a_ff.duty;
   assign rsp_chan.drive_b   = res_b_ff.drive;
   assign rsp_chan.forward_b = res_b_ff.forward;
   assign rsp_chan.duty_b    = res_b_ff.duty;

endmodule

FILE: rtl/core/dipmd_port_checker.sv
// ----------------------------------------------------------------------------
// dipmd_port_checker
// Port-level checks of the dual incremental PI motor drive, bound to the top.
// ----------------------------------------------------------------------------
`include "dual_incremental_pi_motor_drive_top_macros.svh"

module dipmd_port_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [12:0] drive_a,
   input logic               forward_a,
   input logic [11:0]        duty_a,
   input logic signed [12:0] drive_b,
   input logic               forward_b,
   input logic [11:0]        duty_b
);

   `DIPMD_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)
   `DIPMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(drive_a) && $stable(duty_a) && $stable(drive_b) && $stable(duty_b))
   `DIPMD_ASSERT_IMP(a_forward_sign, clock, reset, rsp_valid, (forward_a == (drive_a > 13'sd0)) && (forward_b == (drive_b > 13'sd0)))
   `DIPMD_ASSERT_IMP(a_duty_magnitude, clock, reset, rsp_valid, (duty_a == 12'(drive_a[12] ? -drive_a : drive_a)) && (duty_b == 12'(drive_b[12] ? -drive_b : drive_b)))

endmodule

bind dual_incremental_pi_motor_drive_top dipmd_port_checker u_port_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .drive_a   (rsp_chan.drive_a),
   .forward_a (rsp_chan.forward_a),
   .duty_a    (rsp_chan.duty_a),
   .drive_b   (rsp_chan.drive_b),
   .forward_b (rsp_chan.forward_b),
   .duty_b    (rsp_chan.duty_b)
);

FILE: bench/dipmd_drive_checker.sv
// ----------------------------------------------------------------------------
// dipmd_drive_checker
// Watches the speed and drive channels and the register port of the dual PI
// motor drive. It keeps its own gains, drive accumulators and error history,
// works out the drive command for every accepted speed sample, and compares
// each accepted command, field by field, with the oldest one outstanding.
// ----------------------------------------------------------------------------
module dipmd_drive_checker
   import dipmd_pkg::*;
#(
   parameter int SPEED_W   = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   dipmd_req_if                  req,
   dipmd_rsp_if                  rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           mismatches,
   output int unsigned           cmds_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      drive_result_type motor_a;
      drive_result_type motor_b;
   } drive_pair_type;

   logic [GAIN_W-1:0]         prop_gain;
   logic [GAIN_W-1:0]         integ_gain;
   logic [LIMIT_W-1:0]        drive_limit;
   logic signed [DRIVE_W-1:0] drive_acc [2];
   logic signed [SPEED_W:0]   last_error [2];
   drive_pair_type            expected_cmds [$];

   function automatic drive_result_type pi_step(input int motor,
                                                input logic signed [SPEED_W-1:0] target,
                                                input logic signed [SPEED_W-1:0] measured);
      logic signed [SPEED_W:0] speed_err;
      longint                  scaled;
      longint                  drive;
      longint                  bound;
      drive_result_type        cmd;
      speed_err = target - measured;
      scaled = longint'(drive_acc[motor]) * (longint'(1) <<< FRAC_BITS)
             + longint'(integ_gain) * (longint'(speed_err) - longint'(last_error[motor]))
             + longint'(prop_gain) * longint'(speed_err);
      // truncate toward zero
      drive = scaled / (longint'(1) <<< FRAC_BITS);
      bound = longint'(drive_limit);
      if (drive > bound) begin
         drive = bound;
      end else if (drive < -bound) begin
         drive = -bound;
      end
      drive_acc[motor]  = DRIVE_W'(drive);
      last_error[motor] = speed_err;
      cmd.drive   = DRIVE_W'(drive);
      cmd.forward = (drive > 0);
      cmd.duty    = DUTY_W'(drive < 0 ? -drive : drive);
      return cmd;
   endfunction

   task automatic compare_field(input string what, input int want, input int seen);
      if (want != seen) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      drive_pair_type want;
      if (reset) begin
         prop_gain   = PROP_GAIN_RESET;
         integ_gain  = INTEG_GAIN_RESET;
         drive_limit = DRIVE_LIMIT_RESET;
         drive_acc   = '{default: '0};
         last_error  = '{default: '0};
         expected_cmds.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_cmds.size() == 0) begin
               $display("%0t: unexpected drive command, expected none, actual %0d / %0d",
                        $time, rsp.drive_a, rsp.drive_b);
               mismatches++;
            end else begin
               want = expected_cmds.pop_front();
               compare_field("drive_a", want.motor_a.drive, rsp.drive_a);
               compare_field("forward_a", want.motor_a.forward, rsp.forward_a);
               compare_field("duty_a", want.motor_a.duty, rsp.duty_a);
               compare_field("drive_b", want.motor_b.drive, rsp.drive_b);
               compare_field("forward_b", want.motor_b.forward, rsp.forward_b);
               compare_field("duty_b", want.motor_b.duty, rsp.duty_b);
            end
         end
         if (req.valid && req.ready) begin
            want.motor_a = pi_step(0, req.target_a, req.measured_a);
            want.motor_b = pi_step(1, req.target_b, req.measured_b);
            expected_cmds.push_back(want);
         end
         if (csr_we) begin
            case (csr_idx)
               CSR_PROP_GAIN: begin
                  prop_gain = csr_wdata[GAIN_W-1:0];
               end
               CSR_INTEG_GAIN: begin
                  integ_gain = csr_wdata[GAIN_W-1:0];
               end
               CSR_DRIVE_LIMIT: begin
                  drive_limit = csr_wdata[LIMIT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      cmds_pending = expected_cmds.size();
   end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the dual PI motor drive with directed speed samples (rails, unit
// errors, zero limit, widest and zero gains, masked and spare register
// writes), then with random phases of gains and limits where most samples
// track a set point closely and the rest are full-range noise. Both channels
// idle in random bursts; the checker predicts and compares every command.
// ----------------------------------------------------------------------------
module tb_top
   import dipmd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SPEED_W     = 16;
   localparam int FRAC_BITS   = 8;
   localparam int CYCLE_LIMIT = 200000;

   localparam logic [CSR_IDX_W-1:0]      CSR_SPARE_IDX = 2'd3;
   localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int unsigned           mismatches;
   int unsigned           cmds_pending;
   int unsigned           cycle_count = 0;
   bit                    idle_on;
   bit                    quiet_tail;
   logic signed [SPEED_W-1:0] set_point [2];

   dipmd_req_if #(.SPEED_WIDTH(SPEED_W)) req_chan ();
   dipmd_rsp_if rsp_chan ();

   dual_incremental_pi_motor_drive_top #(
      .SPEED_WIDTH    (SPEED_W),
      .GAIN_FRAC_BITS (FRAC_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   dipmd_drive_checker #(
      .SPEED_W   (SPEED_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .csr_we       (csr_we),
      .csr_idx      (csr_idx),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .cmds_pending (cmds_pending)
   );

   always begin
      #10ns clock = 1'b1;
      #10ns clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // stall the drive command channel in bursts
   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 8);
            rsp_chan.ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic logic signed [SPEED_W-1:0] any_speed();
      case ($urandom_range(0, 7))
         0:       return SPEED_MAX;
         1:       return SPEED_MIN;
         default: return SPEED_W'($urandom);
      endcase
   endfunction

   task automatic send_tick(input logic signed [SPEED_W-1:0] ta, input logic signed [SPEED_W-1:0] ma,
                            input logic signed [SPEED_W-1:0] tb, input logic signed [SPEED_W-1:0] mb);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.target_a   <= ta;
      req_chan.measured_a <= ma;
      req_chan.target_b   <= tb;
      req_chan.measured_b <= mb;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // hold off until every command is out and the pipeline is empty
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (cmds_pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_gains(input logic [GAIN_W-1:0] prop, input logic [GAIN_W-1:0] integ,
                            input logic [LIMIT_W-1:0] limit);
      drain();
      write_csr(CSR_PROP_GAIN, prop);
      write_csr(CSR_INTEG_GAIN, integ);
      write_csr(CSR_DRIVE_LIMIT, CSR_DATA_W'(limit));
   endtask

   task automatic random_ticks(input int count);
      logic signed [SPEED_W-1:0] sample [4];
      int delta;
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0) begin
            idle_on = ($urandom_range(0, 3) != 0) && !quiet_tail;
         end
         for (int m = 0; m < 2; m++) begin
            if ($urandom_range(0, 15) == 0) begin
               set_point[m] = any_speed();
            end
            if ($urandom_range(0, 4) == 0) begin
               sample[2*m]   = any_speed();
               sample[2*m+1] = any_speed();
            end else begin
               delta = int'($urandom_range(0, 64)) - 32;
               sample[2*m]   = set_point[m];
               sample[2*m+1] = set_point[m] + SPEED_W'(delta);
            end
         end
         if (!quiet_tail && $urandom_range(0, 99) == 0) begin
            drain();
         end
         send_tick(sample[0], sample[1], sample[2], sample[3]);
      end
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.target_a   = '0;
      req_chan.measured_a = '0;
      req_chan.target_b   = '0;
      req_chan.measured_b = '0;
      rsp_chan.ready      = 1'b0;
      csr_we              = 1'b0;
      csr_idx             = CSR_PROP_GAIN;
      csr_wdata           = '0;
      idle_on             = 1'b1;
      quiet_tail          = 1'b0;
      set_point           = '{default: '0};
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset gains: zero drive, unit errors, rails
      send_tick(0, 0, 0, 0);
      send_tick(1, 0, -1, 0);
      send_tick(1, 0, -1, 0);
      send_tick(0, 1, 0, -1);
      send_tick(SPEED_MAX, SPEED_MIN, SPEED_MIN, SPEED_MAX);
      send_tick(SPEED_MIN, SPEED_MAX, SPEED_MAX, SPEED_MIN);
      send_tick(SPEED_MAX, SPEED_MAX, SPEED_MIN, SPEED_MIN);
      send_tick(-1, -1, 0, 0);

      // zero limit forces zero drive
      set_gains(PROP_GAIN_RESET, INTEG_GAIN_RESET, '0);
      send_tick(SPEED_MAX, SPEED_MIN, SPEED_MIN, SPEED_MAX);
      send_tick(5, 0, -5, 0);

      set_gains('1, '1, '1);
      send_tick(1, 0, -1, 0);
      send_tick(SPEED_MIN, SPEED_MAX, SPEED_MAX, SPEED_MIN);
      send_tick(0, 0, 0, 0);

      // zero gains: drive holds
      set_gains('0, '0, '1);
      send_tick(SPEED_MAX, SPEED_MIN, SPEED_MIN, SPEED_MAX);
      send_tick(-7, 3, 7, -3);

      // upper limit bits dropped, spare index ignored
      drain();
      write_csr(CSR_DRIVE_LIMIT, 16'hF0C8);
      write_csr(CSR_SPARE_IDX, 16'h0001);
      write_csr(CSR_PROP_GAIN, 16'h0180);
      send_tick(300, 0, -300, 0);
      send_tick(0, 300, 0, -300);
      send_tick(3, 0, -3, 0);

      random_ticks(60);
      set_gains(PROP_GAIN_RESET, INTEG_GAIN_RESET, DRIVE_LIMIT_RESET);
      random_ticks(100);
      set_gains(GAIN_W'($urandom_range(0, 1024)), GAIN_W'($urandom_range(0, 1024)),
                LIMIT_W'($urandom_range(1, 4095)));
      random_ticks(80);
      set_gains('1, '1, '1);
      random_ticks(40);
      set_gains(GAIN_W'($urandom_range(0, 2048)), GAIN_W'($urandom_range(0, 2048)), '0);
      random_ticks(40);
      set_gains(GAIN_W'($urandom_range(0, 512)), GAIN_W'($urandom_range(0, 512)),
                LIMIT_W'($urandom_range(1, 4095)));
      random_ticks(80);

      quiet_tail = 1'b1;
      idle_on    = 1'b0;
      set_gains(PROP_GAIN_RESET, INTEG_GAIN_RESET, LIMIT_W'($urandom_range(1, 4095)));
      random_ticks(80);

      drain();
      repeat (5) @(negedge clock);
      if (mismatches == 0 && cmds_pending == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

FILE: dual_incremental_pi_motor_drive_top.f
+incdir+rtl/core
rtl/core/dipmd_pkg.sv
rtl/core/dipmd_if.sv
rtl/core/dipmd_axis.sv
rtl/core/dual_incremental_pi_motor_drive_top.sv
rtl/core/dipmd_port_checker.sv
bench/dipmd_drive_checker.sv
bench/tb_top.sv
